FILE: rtl/ptvqr_pkg.sv
package ptvqr_pkg;

    // Field widths fixed by the interface.
    localparam int SLOT_W      = 16;
    localparam int KIND_W      = 2;
    localparam int QUAT_W      = 16;
    localparam int OUT_W       = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    // Register map: force vectors first, then torque vectors, one per kind.
    localparam int REG_FORCE_BASE  = 0;
    localparam int REG_TORQUE_BASE = 4;

    localparam logic [CFG_DATA_W-1:0] FORCE_RESET  = 48'd256;
    localparam logic [CFG_DATA_W-1:0] TORQUE_RESET = 48'd0;

    // Rotation matrix entries are exact at scale 2^28 and fit in 34 signed bits.
    localparam int MAT_W       = 34;
    localparam int ROUND_SHIFT = 28;

    // Register stages from an accepted beat to its result.
    localparam int PIPE_DEPTH = 6;

    typedef logic signed [QUAT_W-1:0]   quat_part_t;
    typedef logic signed [2*QUAT_W-1:0] quat_prod_t;
    typedef logic signed [MAT_W-1:0]    mat_entry_t;

endpackage

FILE: rtl/ptvqr_vec_rotate.sv
module ptvqr_vec_rotate
    import ptvqr_pkg::*;
#(
    parameter int COMPONENT_BITS = 16
)
(
    input  logic                             clk,
    input  mat_entry_t                       mat [9],
    input  logic signed [COMPONENT_BITS-1:0] vec [3],
    output logic signed [OUT_W-1:0]          rot [3]
);

    localparam int PROD_W = MAT_W + COMPONENT_BITS;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RND_W  = SUM_W + 1 - ROUND_SHIFT;
    localparam int EXT_W  = (COMPONENT_BITS > OUT_W) ? COMPONENT_BITS : OUT_W;

    localparam logic signed [SUM_W:0] HALF =
        {{(SUM_W + 1 - ROUND_SHIFT){1'b0}}, 1'b1, {(ROUND_SHIFT - 1){1'b0}}};
    localparam logic signed [RND_W-1:0] SAT_MAX =
        {{(RND_W - COMPONENT_BITS + 1){1'b0}}, {(COMPONENT_BITS - 1){1'b1}}};
    localparam logic signed [RND_W-1:0] SAT_MIN =
        {{(RND_W - COMPONENT_BITS + 1){1'b1}}, {(COMPONENT_BITS - 1){1'b0}}};

    logic signed [PROD_W-1:0] prod_next [9];
    logic signed [PROD_W-1:0] prod_reg  [9];
    logic signed [SUM_W-1:0]  sum_next  [3];
    logic signed [SUM_W-1:0]  sum_reg   [3];
    logic signed [OUT_W-1:0]  rot_next  [3];
    logic signed [OUT_W-1:0]  rot_reg   [3];

    // Stage one: one matrix entry times one vector component per multiplier.
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_next[j*3 + k] = mat[j*3 + k] * vec[k];
            end
        end
    end

    // Stage two: the three products of each row are summed exactly.
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sum_next[j] = SUM_W'(prod_reg[j*3]) + SUM_W'(prod_reg[j*3 + 1])
                        + SUM_W'(prod_reg[j*3 + 2]);
        end
    end

    // Stage three: round half up to Q8.8, clamp to the component range and
    // sign-extend or truncate into the output field.
    always_comb
    begin
        logic signed [SUM_W:0]          biased;
        logic signed [RND_W-1:0]        rounded;
        logic signed [COMPONENT_BITS-1:0] clamped;
        logic signed [EXT_W-1:0]        extended;
        for (int j = 0; j < 3; j++)
        begin
            biased  = (SUM_W + 1)'(sum_reg[j]) + HALF;
            rounded = $signed(biased[SUM_W:ROUND_SHIFT]);
            if (rounded > SAT_MAX)
            begin
                clamped = SAT_MAX[COMPONENT_BITS-1:0];
            end
            else if (rounded < SAT_MIN)
            begin
                clamped = SAT_MIN[COMPONENT_BITS-1:0];
            end
            else
            begin
                clamped = rounded[COMPONENT_BITS-1:0];
            end
            extended    = EXT_W'(clamped);
            rot_next[j] = extended[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        rot_reg  <= rot_next;
    end

    assign rot = rot_reg;

endmodule

FILE: rtl/per_type_vector_quaternion_rotate.sv
// Rotates a per-kind force vector and torque vector into the global frame by a
// particle's orientation quaternion (Q2.14), using (s*s - v.v)a + 2s(v x a) +
// 2(v.a)v without normalizing the quaternion, and returns both rotated vectors
// rounded half up and saturated to signed Q8.8. The block is a six-stage
// pipeline that never stalls: busy is always low, a beat may be started on
// every clock, and each beat yields exactly one result. The result is shown
// for one cycle with result_strobe high and cannot be held off, so the
// receiver must take it in that cycle. A non-member particle, or a kind with
// no table entry, gives zero vectors; result_slot always copies particle_slot.
// The force and torque tables are written through cfg_write, cfg_index and
// cfg_data (force of kind i at index i, torque of kind i at index 4 + i);
// write them only while no beat is in flight.
module per_type_vector_quaternion_rotate
    import ptvqr_pkg::*;
#(
    parameter int NUM_KINDS      = 4,
    parameter int COMPONENT_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_write,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,

    input  logic                          start,
    output logic                          busy,
    input  logic [SLOT_W-1:0]             particle_slot,
    input  logic [KIND_W-1:0]             particle_kind,
    input  logic                          member_flag,
    input  logic signed [QUAT_W-1:0]      quat_scalar,
    input  logic signed [QUAT_W-1:0]      quat_vx,
    input  logic signed [QUAT_W-1:0]      quat_vy,
    input  logic signed [QUAT_W-1:0]      quat_vz,

    output logic                          result_strobe,
    output logic [SLOT_W-1:0]             result_slot,
    output logic signed [OUT_W-1:0]       force_gx,
    output logic signed [OUT_W-1:0]       force_gy,
    output logic signed [OUT_W-1:0]       force_gz,
    output logic signed [OUT_W-1:0]       torque_gx,
    output logic signed [OUT_W-1:0]       torque_gy,
    output logic signed [OUT_W-1:0]       torque_gz
);

    localparam int CB    = COMPONENT_BITS;
    // Components are cut from the register zero-extended to at least 3*CB bits,
    // so a component reaching past bit 47 picks up zeros.
    localparam int PAD_W = (3 * CB > CFG_DATA_W) ? 3 * CB : CFG_DATA_W;

    // Per-kind vector tables.
    logic [CFG_DATA_W-1:0] force_reg  [NUM_KINDS];
    logic [CFG_DATA_W-1:0] torque_reg [NUM_KINDS];

    // Control and slot travel alongside the data through every stage.
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [SLOT_W-1:0]     slot_reg [PIPE_DEPTH];

    // Stage 1: quaternion and the looked-up vectors.
    quat_part_t qs_reg, qx_reg, qy_reg, qz_reg;
    // Vectors are delayed three stages to meet the finished matrix.
    logic signed [CB-1:0] fvec_next [3];
    logic signed [CB-1:0] tvec_next [3];
    logic signed [CB-1:0] fvec_reg  [3][3];
    logic signed [CB-1:0] tvec_reg  [3][3];

    // Stage 2: the ten quaternion products.
    quat_prod_t ss_reg, xx_reg, yy_reg, zz_reg;
    quat_prod_t xy_reg, xz_reg, yz_reg, sx_reg, sy_reg, sz_reg;

    // Stage 3: the rotation matrix, row major.
    mat_entry_t mat_next [9];
    mat_entry_t mat_reg  [9];

    logic signed [OUT_W-1:0] force_rot  [3];
    logic signed [OUT_W-1:0] torque_rot [3];

    // Nothing downstream can stall the pipeline.
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KINDS; i++)
            begin
                force_reg[i]  <= FORCE_RESET;
                torque_reg[i] <= TORQUE_RESET;
            end
        end
        else if (cfg_write)
        begin
            for (int i = 0; i < NUM_KINDS; i++)
            begin
                if (cfg_index == CFG_INDEX_W'(REG_FORCE_BASE + i))
                begin
                    force_reg[i] <= cfg_data;
                end
                if (cfg_index == CFG_INDEX_W'(REG_TORQUE_BASE + i))
                begin
                    torque_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Table lookup. A non-member or a kind without an entry selects the zero
    // vector, which the rest of the datapath turns into zero outputs.
    always_comb
    begin
        logic [CFG_DATA_W-1:0] fsel;
        logic [CFG_DATA_W-1:0] tsel;
        logic [PAD_W-1:0]      fpad;
        logic [PAD_W-1:0]      tpad;
        fsel = '0;
        tsel = '0;
        for (int i = 0; i < NUM_KINDS; i++)
        begin
            if (member_flag && particle_kind == KIND_W'(i))
            begin
                fsel = force_reg[i];
                tsel = torque_reg[i];
            end
        end
        fpad = PAD_W'(fsel);
        tpad = PAD_W'(tsel);
        for (int k = 0; k < 3; k++)
        begin
            fvec_next[k] = $signed(fpad[k*CB +: CB]);
            tvec_next[k] = $signed(tpad[k*CB +: CB]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], start};
        end
    end

    // Matrix entries from the products, each exact at scale 2^28.
    always_comb
    begin
        mat_entry_t ss, xx, yy, zz, xy, xz, yz, sx, sy, sz;
        ss = MAT_W'(ss_reg);
        xx = MAT_W'(xx_reg);
        yy = MAT_W'(yy_reg);
        zz = MAT_W'(zz_reg);
        xy = MAT_W'(xy_reg);
        xz = MAT_W'(xz_reg);
        yz = MAT_W'(yz_reg);
        sx = MAT_W'(sx_reg);
        sy = MAT_W'(sy_reg);
        sz = MAT_W'(sz_reg);
        mat_next[0] = ss + xx - yy - zz;
        mat_next[1] = (xy - sz) <<< 1;
        mat_next[2] = (xz + sy) <<< 1;
        mat_next[3] = (xy + sz) <<< 1;
        mat_next[4] = ss - xx + yy - zz;
        mat_next[5] = (yz - sx) <<< 1;
        mat_next[6] = (xz - sy) <<< 1;
        mat_next[7] = (yz + sx) <<< 1;
        mat_next[8] = ss - xx - yy + zz;
    end

    // Payload registers load every cycle; the valid bits say which are live.
    always_ff @(posedge clk)
    begin
        slot_reg[0] <= particle_slot;
        for (int i = 1; i < PIPE_DEPTH; i++)
        begin
            slot_reg[i] <= slot_reg[i-1];
        end

        qs_reg <= quat_scalar;
        qx_reg <= quat_vx;
        qy_reg <= quat_vy;
        qz_reg <= quat_vz;

        fvec_reg[0] <= fvec_next;
        tvec_reg[0] <= tvec_next;
        fvec_reg[1] <= fvec_reg[0];
        tvec_reg[1] <= tvec_reg[0];
        fvec_reg[2] <= fvec_reg[1];
        tvec_reg[2] <= tvec_reg[1];

        ss_reg <= qs_reg * qs_reg;
        xx_reg <= qx_reg * qx_reg;
        yy_reg <= qy_reg * qy_reg;
        zz_reg <= qz_reg * qz_reg;
        xy_reg <= qx_reg * qy_reg;
        xz_reg <= qx_reg * qz_reg;
        yz_reg <= qy_reg * qz_reg;
        sx_reg <= qs_reg * qx_reg;
        sy_reg <= qs_reg * qy_reg;
        sz_reg <= qs_reg * qz_reg;

        mat_reg <= mat_next;
    end

    // Stages 4 to 6: matrix times vector, row sums, rounding and saturation.
    ptvqr_vec_rotate #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_force_rotate (
        .clk (clk),
        .mat (mat_reg),
        .vec (fvec_reg[2]),
        .rot (force_rot)
    );

    ptvqr_vec_rotate #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_torque_rotate (
        .clk (clk),
        .mat (mat_reg),
        .vec (tvec_reg[2]),
        .rot (torque_rot)
    );

    assign result_strobe = valid_reg[PIPE_DEPTH-1];
    assign result_slot   = slot_reg[PIPE_DEPTH-1];
    assign force_gx      = force_rot[0];
    assign force_gy      = force_rot[1];
    assign force_gz      = force_rot[2];
    assign torque_gx     = torque_rot[0];
    assign torque_gy     = torque_rot[1];
    assign torque_gz     = torque_rot[2];

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

import ptvqr_pkg::*;

// One rotated force/torque pair as it leaves the block.
typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [OUT_W-1:0]  fx;
    logic [OUT_W-1:0]  fy;
    logic [OUT_W-1:0]  fz;
    logic [OUT_W-1:0]  tx;
    logic [OUT_W-1:0]  ty;
    logic [OUT_W-1:0]  tz;
} rotated_pair_t;

class rotation_scoreboard;

    localparam int COMP_W    = 16;
    localparam int KIND_SLOTS = 4;
    localparam int REPORT_MAX = 10;

    logic [CFG_DATA_W-1:0] force_tab [KIND_SLOTS];
    logic [CFG_DATA_W-1:0] torque_tab [KIND_SLOTS];
    rotated_pair_t         rotated_q [$];
    int                    errors;
    int                    compared;

    function new();
        for (int k = 0; k < KIND_SLOTS; k++)
        begin
            force_tab[k]  = FORCE_RESET;
            torque_tab[k] = TORQUE_RESET;
        end
        errors   = 0;
        compared = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        if (idx < REG_TORQUE_BASE)
            force_tab[idx - REG_FORCE_BASE] = value;
        else
            torque_tab[idx - REG_TORQUE_BASE] = value;
    endfunction

    function longint vec_comp(logic [CFG_DATA_W-1:0] vec, int k);
        logic signed [COMP_W-1:0] c;
        c = vec[k*COMP_W +: COMP_W];
        return longint'(c);
    endfunction

    // Dot product of one matrix row with the vector, rounded half up to Q8.8
    // and clamped to the signed output range.
    function logic [OUT_W-1:0] rotate_row(longint r0, longint r1, longint r2,
                                          longint a0, longint a1, longint a2);
        longint acc;
        longint q;
        longint hi_lim;
        hi_lim = (longint'(1) <<< (OUT_W - 1)) - 1;
        acc = r0 * a0 + r1 * a1 + r2 * a2;
        q = (acc + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        if (q > hi_lim)
            q = hi_lim;
        else if (q < -hi_lim - 1)
            q = -hi_lim - 1;
        return q[OUT_W-1:0];
    endfunction

    function void note(logic [SLOT_W-1:0] slot, logic [KIND_W-1:0] kind, logic member,
                       logic signed [QUAT_W-1:0] qs, logic signed [QUAT_W-1:0] qx,
                       logic signed [QUAT_W-1:0] qy, logic signed [QUAT_W-1:0] qz);
        longint        s, x, y, z;
        longint        m [3][3];
        longint        fa [3];
        longint        ta [3];
        logic [OUT_W-1:0] fo [3];
        logic [OUT_W-1:0] to [3];
        rotated_pair_t exp_pair;
        bit            active;
        s = longint'(qs);
        x = longint'(qx);
        y = longint'(qy);
        z = longint'(qz);
        m[0][0] = s * s + x * x - y * y - z * z;
        m[0][1] = 2 * (x * y - s * z);
        m[0][2] = 2 * (x * z + s * y);
        m[1][0] = 2 * (x * y + s * z);
        m[1][1] = s * s - x * x + y * y - z * z;
        m[1][2] = 2 * (y * z - s * x);
        m[2][0] = 2 * (x * z - s * y);
        m[2][1] = 2 * (y * z + s * x);
        m[2][2] = s * s - x * x - y * y + z * z;
        active = member && (int'(kind) < KIND_SLOTS);
        for (int k = 0; k < 3; k++)
        begin
            fa[k] = active ? vec_comp(force_tab[kind], k) : 0;
            ta[k] = active ? vec_comp(torque_tab[kind], k) : 0;
        end
        for (int j = 0; j < 3; j++)
        begin
            fo[j] = active ? rotate_row(m[j][0], m[j][1], m[j][2], fa[0], fa[1], fa[2]) : '0;
            to[j] = active ? rotate_row(m[j][0], m[j][1], m[j][2], ta[0], ta[1], ta[2]) : '0;
        end
        exp_pair.slot = slot;
        exp_pair.fx = fo[0];
        exp_pair.fy = fo[1];
        exp_pair.fz = fo[2];
        exp_pair.tx = to[0];
        exp_pair.ty = to[1];
        exp_pair.tz = to[2];
        rotated_q.push_back(exp_pair);
    endfunction

    function void check(rotated_pair_t got);
        rotated_pair_t want;
        if (rotated_q.size() == 0)
        begin
            errors++;
            if (errors <= REPORT_MAX)
                $display("ERROR: result for slot %h arrived with nothing outstanding",
                         got.slot);
            return;
        end
        want = rotated_q.pop_front();
        compared++;
        if (got.slot !== want.slot || got.fx !== want.fx || got.fy !== want.fy ||
            got.fz !== want.fz || got.tx !== want.tx || got.ty !== want.ty ||
            got.tz !== want.tz)
        begin
            errors++;
            if (errors <= REPORT_MAX)
            begin
                $display("ERROR: expected slot %h f=(%h %h %h) t=(%h %h %h)",
                         want.slot, want.fx, want.fy, want.fz, want.tx, want.ty, want.tz);
                $display("       got      slot %h f=(%h %h %h) t=(%h %h %h)",
                         got.slot, got.fx, got.fy, got.fz, got.tx, got.ty, got.tz);
            end
        end
    endfunction

    function int pending();
        return rotated_q.size();
    endfunction

endclass

module tb;

    // The watchdog ends the run after this many cycles with no beat, no result
    // and no register write.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = PIPE_DEPTH + 4;
    localparam int PHASES         = 4;
    localparam int BEATS_PER_PHASE = 120;
    localparam logic signed [QUAT_W-1:0] Q_ONE  = 16'sd16384;
    localparam logic signed [QUAT_W-1:0] Q_HALF = 16'sd8192;
    localparam logic signed [QUAT_W-1:0] Q_R45  = 16'sd11585;
    localparam logic signed [QUAT_W-1:0] Q_MAX  = 16'sh7FFF;
    localparam logic signed [QUAT_W-1:0] Q_MIN  = 16'sh8000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [SLOT_W-1:0]        particle_slot = '0;
    logic [KIND_W-1:0]        particle_kind = '0;
    logic                     member_flag = 1'b0;
    logic signed [QUAT_W-1:0] quat_scalar = '0;
    logic signed [QUAT_W-1:0] quat_vx = '0;
    logic signed [QUAT_W-1:0] quat_vy = '0;
    logic signed [QUAT_W-1:0] quat_vz = '0;
    logic                     result_strobe;
    logic [SLOT_W-1:0]        result_slot;
    logic signed [OUT_W-1:0]  force_gx;
    logic signed [OUT_W-1:0]  force_gy;
    logic signed [OUT_W-1:0]  force_gz;
    logic signed [OUT_W-1:0]  torque_gx;
    logic signed [OUT_W-1:0]  torque_gy;
    logic signed [OUT_W-1:0]  torque_gz;

    rotation_scoreboard    sb;
    logic [CFG_DATA_W-1:0] force_set [4];
    logic [CFG_DATA_W-1:0] torque_set [4];
    int                    sender_idle_pct = 0;
    int                    beats_sent = 0;
    int                    non_members = 0;
    int                    table_loads = 0;
    int                    quiet_cycles = 0;

    per_type_vector_quaternion_rotate u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .particle_slot (particle_slot),
        .particle_kind (particle_kind),
        .member_flag   (member_flag),
        .quat_scalar   (quat_scalar),
        .quat_vx       (quat_vx),
        .quat_vy       (quat_vy),
        .quat_vz       (quat_vz),
        .result_strobe (result_strobe),
        .result_slot   (result_slot),
        .force_gx      (force_gx),
        .force_gy      (force_gy),
        .force_gz      (force_gz),
        .torque_gx     (torque_gx),
        .torque_gy     (torque_gy),
        .torque_gz     (torque_gz)
    );

    always #4 clk = ~clk;

    // Monitor. Everything here samples the values that were present at the
    // rising edge, since all stimulus is driven with nonblocking assignments on
    // that same edge. A result is checked before a new beat is noted; the two
    // never belong together because the pipeline is several stages deep.
    always @(posedge clk)
    begin
        rotated_pair_t got;
        if (rst_n)
        begin
            if (cfg_write)
                sb.write_reg(cfg_index, cfg_data);
            if (result_strobe)
            begin
                got.slot = result_slot;
                got.fx = force_gx;
                got.fy = force_gy;
                got.fz = force_gz;
                got.tx = torque_gx;
                got.ty = torque_gy;
                got.tz = torque_gz;
                sb.check(got);
            end
            if (start && !busy)
                sb.note(particle_slot, particle_kind, member_flag,
                        quat_scalar, quat_vx, quat_vy, quat_vz);
            if (cfg_write || result_strobe || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d results outstanding", sb.pending());
                $display("** per_type_vector_quaternion_rotate: FAILED **");
                $finish;
            end
        end
    end

    // Drives one beat. Before it, the sender may sit idle for a random number
    // of cycles; start is only lowered for such a gap, so back-to-back beats
    // keep start high across the boundary.
    task automatic send_beat(input logic [SLOT_W-1:0] slot, input logic [KIND_W-1:0] kind,
                             input logic member, input logic signed [QUAT_W-1:0] qs,
                             input logic signed [QUAT_W-1:0] qx,
                             input logic signed [QUAT_W-1:0] qy,
                             input logic signed [QUAT_W-1:0] qz);
        while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start         <= 1'b1;
        particle_slot <= slot;
        particle_kind <= kind;
        member_flag   <= member;
        quat_scalar   <= qs;
        quat_vx       <= qx;
        quat_vy       <= qy;
        quat_vz       <= qz;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        beats_sent++;
        if (!member)
            non_members++;
    endtask

    // Holds the sender off until every outstanding result has come back, then
    // lets the pipeline run empty for a few more cycles.
    task automatic settle_pipeline();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all eight table registers from force_set and torque_set, one per
    // cycle, with the write enable held high across the burst.
    task automatic program_tables();
        for (int k = 0; k < 4; k++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_INDEX_W'(REG_FORCE_BASE + k);
            cfg_data  <= force_set[k];
            @(posedge clk);
        end
        for (int k = 0; k < 4; k++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_INDEX_W'(REG_TORQUE_BASE + k);
            cfg_data  <= torque_set[k];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        table_loads++;
    endtask

    // Table components lean toward the range ends and the unit value.
    function automatic logic [15:0] pick_component();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'h0100;
            4: return 16'hFF00;
            5: return 16'($urandom_range(0, 1023) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // Returns {s, x, y, z}. Half are close to unit length, the way real
    // orientations look; the rest are raw bit patterns, tiny values and
    // corner values that push the products into saturation.
    function automatic logic [4*QUAT_W-1:0] pick_quaternion();
        real                      w [4];
        real                      norm;
        logic [4*QUAT_W-1:0]      q;
        logic signed [QUAT_W-1:0] corner [4];
        corner[0] = Q_MAX;
        corner[1] = Q_MIN;
        corner[2] = '0;
        corner[3] = Q_ONE;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                for (int k = 0; k < 4; k++)
                    w[k] = ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
                norm = $sqrt(w[0] * w[0] + w[1] * w[1] + w[2] * w[2] + w[3] * w[3]);
                if (norm < 0.001)
                begin
                    w[0] = 1.0;
                    w[1] = 0.0;
                    w[2] = 0.0;
                    w[3] = 0.0;
                    norm = 1.0;
                end
                for (int k = 0; k < 4; k++)
                    q[k*QUAT_W +: QUAT_W] = QUAT_W'($rtoi(w[k] * 16384.0 / norm));
            end
            5, 6, 7:
                q = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
            8:
                for (int k = 0; k < 4; k++)
                    q[k*QUAT_W +: QUAT_W] = QUAT_W'($urandom_range(0, 63) - 32);
            default:
                for (int k = 0; k < 4; k++)
                    q[k*QUAT_W +: QUAT_W] = corner[$urandom_range(0, 3)];
        endcase
        return q;
    endfunction

    task automatic random_beat();
        logic [4*QUAT_W-1:0] q;
        q = pick_quaternion();
        send_beat(16'($urandom), 2'($urandom_range(0, 3)), ($urandom_range(0, 4) != 0),
                  q[3*QUAT_W +: QUAT_W], q[2*QUAT_W +: QUAT_W],
                  q[QUAT_W +: QUAT_W], q[0 +: QUAT_W]);
    endtask

    // Sender idle percentage for each random phase. The receiver side cannot
    // hold results off, so only the sender varies.
    int idle_plan [PHASES] = '{0, 57, 15, 0};

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // With the tables as they come out of reset: force is +1.0 along x and
        // torque is zero for every kind.
        send_beat(16'h0000, 2'd0, 1'b1, Q_ONE, '0, '0, '0);
        send_beat(16'hFFFF, 2'd1, 1'b1, Q_R45, '0, '0, Q_R45);
        send_beat(16'h1234, 2'd2, 1'b1, '0, '0, '0, '0);
        settle_pipeline();

        // Directed tables with components at the extremes, at unit values and at small values.
        force_set[0]  = {16'h0001, 16'h8000, 16'h7FFF};
        force_set[1]  = {16'h0000, 16'h0100, 16'h0000};
        force_set[2]  = {16'h7FFF, 16'h7FFF, 16'h7FFF};
        force_set[3]  = {16'h8000, 16'h8000, 16'h8000};
        torque_set[0] = {16'h0100, 16'h0000, 16'h0000};
        torque_set[1] = {16'hFF00, 16'h0080, 16'hFFFF};
        torque_set[2] = 48'hFFFF_FFFF_FFFF;
        torque_set[3] = 48'h0;
        program_tables();
        for (int k = 0; k < 4; k++)
            send_beat(16'(16'h0100 + k), 2'(k), 1'b1, Q_ONE, '0, '0, '0);
        send_beat(16'h0200, 2'd1, 1'b1, '0, Q_ONE, '0, '0);
        send_beat(16'h0201, 2'd2, 1'b1, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_beat(16'h0202, 2'd3, 1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_beat(16'h0203, 2'd0, 1'b1, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        // Non-members come back as zero vectors with the slot still copied.
        send_beat(16'hFFFF, 2'd2, 1'b0, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_beat(16'h0000, 2'd0, 1'b0, Q_ONE, '0, '0, '0);
        send_beat(16'h0204, 2'd0, 1'b1, Q_R45, '0, Q_R45, '0);
        send_beat(16'h0205, 2'd1, 1'b1, 16'sd1, 16'sd1, -16'sd1, 16'sd1);
        send_beat(16'h0206, 2'd2, 1'b1, -Q_ONE, '0, '0, '0);
        send_beat(16'h0207, 2'd3, 1'b1, '0, '0, '0, Q_ONE);
        send_beat(16'h0208, 2'd1, 1'b1, Q_HALF, Q_HALF, Q_HALF, Q_HALF);
        settle_pipeline();

        // Random phases. The first two fill every force entry with the maximum and
        // every torque entry with the minimum, then the reverse; the rest draw at random.
        for (int p = 0; p < PHASES; p++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (p == 0)
                begin
                    force_set[k]  = {3{16'h7FFF}};
                    torque_set[k] = {3{16'h8000}};
                end
                else if (p == 1)
                begin
                    force_set[k]  = {3{16'h8000}};
                    torque_set[k] = {3{16'h7FFF}};
                end
                else
                begin
                    force_set[k]  = {pick_component(), pick_component(), pick_component()};
                    torque_set[k] = {pick_component(), pick_component(), pick_component()};
                end
            end
            program_tables();
            sender_idle_pct = idle_plan[p];
            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                random_beat();
                // Now and then the sender stops until the pipeline is empty.
                if (n == BEATS_PER_PHASE / 2 || $urandom_range(0, 49) == 0)
                    settle_pipeline();
            end
            settle_pipeline();
        end

        $display("Sent %0d beats (%0d non-member) over %0d table loads; %0d results compared.",
                 beats_sent, non_members, table_loads, sb.compared);
        $display("Sender idle levels 0, 15 and 57 percent, with extreme and random tables.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** per_type_vector_quaternion_rotate: PASSED **");
        else
            $display("** per_type_vector_quaternion_rotate: FAILED **");
        $finish;
    end

endmodule
